// ===== design/rdve_pkg.sv =====
`timescale 1ns / 1ps

package rdve_pkg;

  localparam int VALUE_W    = 32;
  localparam int DIGIT_W    = 4;
  localparam int TOUCH_W    = 16;
  localparam int STEP_W     = 8;
  localparam int DOT_W      = 4;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  // screen x positions: unit_x minus up to ten glyphs and three gaps
  localparam int XPOS_W     = 18;
  // magnitude of -2^31 needs the extra bit
  localparam int ABS_W      = 33;
  localparam int POW_W      = 30;
  localparam int PROD_W     = 39;
  localparam int ACC_W      = 41;
  localparam logic [DIGIT_W-1:0] MAX_DIGIT = 4'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_VALUE     = 3'd0,
    REG_MAX_VALUE     = 3'd1,
    REG_LOCKED        = 3'd2,
    REG_DOT_POSITION  = 3'd3,
    REG_GLYPH_WIDTH   = 3'd4,
    REG_GROUP_SPACING = 3'd5,
    REG_UNIT_X        = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_WALK,
    ST_MUL,
    ST_ADD,
    ST_CLAMP_A,
    ST_CLAMP_B,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic walk_adv;
    logic walk_commit;
    logic mul;
    logic add;
    logic clamp;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic locked;
    logic touch_sel;
    logic step_nz;
    logic walk_stop;
  } dp_status_t;

  function automatic logic [POW_W-1:0] pow10(input logic [DIGIT_W-1:0] d);
    logic [POW_W-1:0] p;
    case (d)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = 30'd0;
    endcase
    return p;
  endfunction

  // largest magnitude that still fits in k digits
  function automatic logic [ABS_W-1:0] pow10_m1(input logic [DIGIT_W-1:0] k);
    logic [ABS_W-1:0] p;
    case (k)
      4'd1:    p = 33'd9;
      4'd2:    p = 33'd99;
      4'd3:    p = 33'd999;
      4'd4:    p = 33'd9999;
      4'd5:    p = 33'd99999;
      4'd6:    p = 33'd999999;
      4'd7:    p = 33'd9999999;
      4'd8:    p = 33'd99999999;
      4'd9:    p = 33'd999999999;
      default: p = 33'd0;
    endcase
    return p;
  endfunction

  // (1 - dot) mod 3: phase of the first digit left of digit 0
  function automatic logic [1:0] phase_init(input logic [DOT_W-1:0] dot);
    logic [1:0] r;
    case (dot)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd1;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd0;
      default:                              r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

// ===== design/rdve_cfg_if.sv =====
`timescale 1ns / 1ps

interface rdve_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rdve_pkg::CFG_IDX_W-1:0]     index;
  logic [rdve_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/rdve_item_if.sv =====
`timescale 1ns / 1ps

interface rdve_item_if;
  logic                               valid;
  logic                               ready;
  logic                               pressed;
  logic                               disabled;
  logic signed [rdve_pkg::TOUCH_W-1:0] touch_x;
  logic signed [rdve_pkg::STEP_W-1:0]  step;
  logic                               value_write;
  logic signed [rdve_pkg::VALUE_W-1:0] new_value;

  modport source (output valid, pressed, disabled, touch_x, step, value_write, new_value,
                  input ready);
  modport sink   (input valid, pressed, disabled, touch_x, step, value_write, new_value,
                  output ready);
endinterface

// ===== design/rdve_result_if.sv =====
`timescale 1ns / 1ps

interface rdve_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [rdve_pkg::VALUE_W-1:0] value;
  logic [rdve_pkg::DIGIT_W-1:0]       selected_digit;
  logic                               refresh;

  modport source (output valid, value, selected_digit, refresh, input ready);
  modport sink   (input valid, value, selected_digit, refresh, output ready);
endinterface

// ===== design/rdve_datapath.sv =====
`timescale 1ns / 1ps

module rdve_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rdve_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rdve_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                pressed,
  input  logic                                disabled,
  input  logic signed [rdve_pkg::TOUCH_W-1:0] touch_x,
  input  logic signed [rdve_pkg::STEP_W-1:0]  step,
  input  logic                                value_write,
  input  logic signed [rdve_pkg::VALUE_W-1:0] new_value,
  input  rdve_pkg::dp_cmd_t                   cmd,
  output rdve_pkg::dp_status_t                status,
  output logic signed [rdve_pkg::VALUE_W-1:0] out_value,
  output logic [rdve_pkg::DIGIT_W-1:0]        out_selected_digit,
  output logic                                out_refresh
);

  localparam int VW = rdve_pkg::VALUE_W;
  localparam int XW = rdve_pkg::XPOS_W;
  localparam int AW = rdve_pkg::ACC_W;

  // configuration
  logic signed [VW-1:0]                  min_value;
  logic signed [VW-1:0]                  max_value;
  logic                                  locked;
  logic [rdve_pkg::DOT_W-1:0]            dot_position;
  logic [rdve_pkg::PIX_W-1:0]            glyph_width;
  logic [rdve_pkg::PIX_W-1:0]            group_spacing;
  logic signed [rdve_pkg::TOUCH_W-1:0]   unit_x;

  // held state; current_value also stands for the last shown value
  logic signed [VW-1:0]                  current_value;
  logic [rdve_pkg::DIGIT_W-1:0]          digit_select;

  // per-request working registers
  logic signed [rdve_pkg::TOUCH_W-1:0]   tx;
  logic signed [rdve_pkg::STEP_W-1:0]    step_r;
  logic                                  touch_sel;
  logic signed [AW-1:0]                  acc;
  logic [rdve_pkg::ABS_W-1:0]            abs_min;
  logic [rdve_pkg::ABS_W-1:0]            abs_max;
  logic [rdve_pkg::ABS_W-1:0]            top;
  logic signed [XW-1:0]                  xpos;
  logic [1:0]                            phase;
  logic [rdve_pkg::DIGIT_W-1:0]          d;
  logic signed [rdve_pkg::PROD_W-1:0]    prod;
  logic                                  sel_changed;

  logic signed [VW-1:0]                  load_value;
  logic signed [rdve_pkg::ABS_W-1:0]     min_ext;
  logic signed [rdve_pkg::ABS_W-1:0]     max_ext;
  logic signed [XW-1:0]                  gw_ext;
  logic signed [XW-1:0]                  sp_ext;
  logic signed [XW-1:0]                  tx_ext;
  logic signed [XW-1:0]                  xpos_next;
  logic [rdve_pkg::DIGIT_W-1:0]          d_inc;
  logic                                  next_ok;
  logic signed [rdve_pkg::PROD_W-1:0]    prod_c;
  logic signed [AW-1:0]                  min_acc;
  logic signed [AW-1:0]                  max_acc;
  logic signed [AW-1:0]                  acc_clamped;

  assign load_value = value_write ? new_value : current_value;
  assign min_ext    = {min_value[VW-1], min_value};
  assign max_ext    = {max_value[VW-1], max_value};
  assign gw_ext     = $signed({{(XW-rdve_pkg::PIX_W){1'b0}}, glyph_width});
  assign sp_ext     = $signed({{(XW-rdve_pkg::PIX_W){1'b0}}, group_spacing});
  assign tx_ext     = {{(XW-rdve_pkg::TOUCH_W){tx[rdve_pkg::TOUCH_W-1]}}, tx};
  assign xpos_next  = xpos - gw_ext - ((phase == 2'd0) ? sp_ext : '0);
  assign d_inc      = d + 4'd1;
  assign next_ok    = (d < rdve_pkg::MAX_DIGIT) && (top > rdve_pkg::pow10_m1(d_inc));

  assign prod_c = step_r * $signed({1'b0, rdve_pkg::pow10(digit_select)});

  assign min_acc = {{(AW-VW){min_value[VW-1]}}, min_value};
  assign max_acc = {{(AW-VW){max_value[VW-1]}}, max_value};
  // min is tested first: on a crossed range values below min get min, all others max
  assign acc_clamped = (acc < min_acc) ? min_acc : ((acc > max_acc) ? max_acc : acc);

  assign status.locked    = locked;
  assign status.touch_sel = touch_sel;
  assign status.step_nz   = (step_r != '0);
  assign status.walk_stop = (tx_ext > xpos) || !next_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_value     <= {1'b1, {(VW-1){1'b0}}};
      max_value     <= {1'b0, {(VW-1){1'b1}}};
      locked        <= 1'b0;
      dot_position  <= 4'd0;
      glyph_width   <= 8'd8;
      group_spacing <= 8'd4;
      unit_x        <= '0;
      current_value <= '0;
      digit_select  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rdve_pkg::REG_MIN_VALUE: begin
            min_value    <= cfg_data[VW-1:0];
            digit_select <= '0;
          end
          rdve_pkg::REG_MAX_VALUE: begin
            max_value    <= cfg_data[VW-1:0];
            digit_select <= '0;
          end
          rdve_pkg::REG_LOCKED:        locked        <= cfg_data[0];
          rdve_pkg::REG_DOT_POSITION:  dot_position  <= cfg_data[rdve_pkg::DOT_W-1:0];
          rdve_pkg::REG_GLYPH_WIDTH:   glyph_width   <= cfg_data[rdve_pkg::PIX_W-1:0];
          rdve_pkg::REG_GROUP_SPACING: group_spacing <= cfg_data[rdve_pkg::PIX_W-1:0];
          rdve_pkg::REG_UNIT_X:        unit_x        <= cfg_data[rdve_pkg::TOUCH_W-1:0];
          default: ;
        endcase
      end
      if (cmd.walk_commit) digit_select  <= d;
      if (cmd.fin)         current_value <= acc[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tx          <= touch_x;
      step_r      <= step;
      touch_sel   <= pressed & ~disabled;
      acc         <= {{(AW-VW){load_value[VW-1]}}, load_value};
      abs_min     <= min_value[VW-1] ? $unsigned(-min_ext) : $unsigned(min_ext);
      abs_max     <= max_value[VW-1] ? $unsigned(-max_ext) : $unsigned(max_ext);
      sel_changed <= 1'b0;
    end
    if (cmd.prep) begin
      top   <= (abs_min > abs_max) ? abs_min : abs_max;
      xpos  <= {{(XW-rdve_pkg::TOUCH_W){unit_x[rdve_pkg::TOUCH_W-1]}}, unit_x} - gw_ext;
      phase <= rdve_pkg::phase_init(dot_position);
      d     <= '0;
    end
    if (cmd.walk_adv) begin
      d     <= d_inc;
      xpos  <= xpos_next;
      phase <= (phase == 2'd2) ? 2'd0 : phase + 2'd1;
    end
    if (cmd.walk_commit) sel_changed <= (d != digit_select);
    if (cmd.mul)         prod <= prod_c;
    if (cmd.add)         acc  <= acc + {{(AW-rdve_pkg::PROD_W){prod[rdve_pkg::PROD_W-1]}}, prod};
    if (cmd.clamp)       acc  <= acc_clamped;
    if (cmd.fin) begin
      out_value          <= acc[VW-1:0];
      out_selected_digit <= digit_select;
      out_refresh        <= sel_changed | (acc[VW-1:0] != current_value);
    end
  end

endmodule

// ===== design/rdve_ctrl.sv =====
`timescale 1ns / 1ps

module rdve_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  output logic                 result_valid,
  input  logic                 result_ready,
  input  rdve_pkg::dp_status_t status,
  output rdve_pkg::dp_cmd_t    cmd
);

  rdve_pkg::state_t state;
  rdve_pkg::state_t state_next;
  logic             slot_free;

  assign slot_free = ~result_valid | result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rdve_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.fin)           result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rdve_pkg::ST_IDLE:    if (item_valid) state_next = rdve_pkg::ST_PREP;
      rdve_pkg::ST_PREP: begin
        if (status.locked)         state_next = rdve_pkg::ST_CLAMP_B;
        else if (status.touch_sel) state_next = rdve_pkg::ST_WALK;
        else if (status.step_nz)   state_next = rdve_pkg::ST_MUL;
        else                       state_next = rdve_pkg::ST_CLAMP_B;
      end
      rdve_pkg::ST_WALK:    if (status.walk_stop) state_next = rdve_pkg::ST_CLAMP_B;
      rdve_pkg::ST_MUL:     state_next = rdve_pkg::ST_ADD;
      rdve_pkg::ST_ADD:     state_next = rdve_pkg::ST_CLAMP_A;
      rdve_pkg::ST_CLAMP_A: state_next = rdve_pkg::ST_CLAMP_B;
      rdve_pkg::ST_CLAMP_B: state_next = rdve_pkg::ST_FIN;
      rdve_pkg::ST_FIN:     if (slot_free) state_next = rdve_pkg::ST_IDLE;
      default:              state_next = rdve_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      rdve_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        cmd.load   = item_valid;
      end
      rdve_pkg::ST_PREP: cmd.prep = 1'b1;
      rdve_pkg::ST_WALK: begin
        cmd.walk_adv    = ~status.walk_stop;
        cmd.walk_commit = status.walk_stop;
      end
      rdve_pkg::ST_MUL:     cmd.mul   = 1'b1;
      rdve_pkg::ST_ADD:     cmd.add   = 1'b1;
      rdve_pkg::ST_CLAMP_A: cmd.clamp = 1'b1;
      rdve_pkg::ST_CLAMP_B: cmd.clamp = 1'b1;
      rdve_pkg::ST_FIN:     cmd.fin   = slot_free;
      default: ;
    endcase
  end

endmodule

// ===== design/rotary_digit_value_editor_core.sv =====
`timescale 1ns / 1ps

// Digit-wise value editor for a rotary encoder plus touch screen. Each request
// (one UI tick) returns exactly one result: the clamped value, the selected
// decimal digit and a refresh flag. A locked or idle request passes through
// prep, one clamp and finish; an encoder step adds a multiply, a 41-bit add
// and a second clamp; a touch walks 1..10 digit positions between prep and
// the clamp, one digit a cycle through a single x-position subtractor. One
// request is worked at a time; the result register lets a new request be
// taken while a result waits. The configuration port is always ready;
// writing min or max clears the selected digit.
module rotary_digit_value_editor_core (
  input  logic          clk,
  input  logic          rst,
  rdve_cfg_if.sink      cfg,
  rdve_item_if.sink     item,
  rdve_result_if.source result
);

  rdve_pkg::dp_cmd_t    cmd;
  rdve_pkg::dp_status_t status;

  // config writes are never back-pressured
  assign cfg.ready = 1'b1;

  // sequencer: decides between lock, touch walk and encoder step
  rdve_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (status),
    .cmd          (cmd)
  );

  // registers, digit walk, step multiply and clamp
  rdve_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg.valid),
    .cfg_index          (cfg.index),
    .cfg_data           (cfg.data),
    .pressed            (item.pressed),
    .disabled           (item.disabled),
    .touch_x            (item.touch_x),
    .step               (item.step),
    .value_write        (item.value_write),
    .new_value          (item.new_value),
    .cmd                (cmd),
    .status             (status),
    .out_value          (result.value),
    .out_selected_digit (result.selected_digit),
    .out_refresh        (result.refresh)
  );

endmodule

// ===== design/rdve_checker.sv =====
`timescale 1ns / 1ps

module rdve_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                item_valid,
  input logic                                item_ready,
  input logic                                result_valid,
  input logic                                result_ready,
  input logic signed [rdve_pkg::VALUE_W-1:0] result_value,
  input logic [rdve_pkg::DIGIT_W-1:0]        result_digit
);

  // no result straight out of reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // one request at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("request accepted while busy");

  // digit never exceeds the top decimal place
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_digit <= rdve_pkg::MAX_DIGIT)
    else $error("selected digit out of range");

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(result_value) && $stable(result_digit))
    else $error("stalled result changed");

endmodule

bind rotary_digit_value_editor_core rdve_checker u_rdve_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_value (result.value),
  .result_digit (result.selected_digit)
);

// ===== tb/rotary_digit_value_editor_core_checker.sv =====
`timescale 1ns / 1ps

// Watches the register, request and result channels. Predicts each result of
// the digit editor and compares it with what the block returns.
module rotary_digit_value_editor_core_checker
  import rdve_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  rdve_cfg_if    cfg,
  rdve_item_if   item,
  rdve_result_if result,
  output int     mismatches,
  output int     outstanding,
  output int     results_seen
);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [DIGIT_W-1:0]        digit;
    logic                      refresh;
  } editor_view_t;

  // predicted register and state copies
  logic signed [VALUE_W-1:0] lo_limit, hi_limit, cur_val, shown_val;
  logic signed [TOUCH_W-1:0] unit_edge;
  logic                      lock_en;
  logic [DOT_W-1:0]          dot_pos;
  logic [PIX_W-1:0]          glyph_w, gap_w;
  logic [DIGIT_W-1:0]        sel_digit;

  editor_view_t view_q[$];
  int fail_count = 0;
  int seen_count = 0;
  int waiting = 0;

  assign mismatches   = fail_count;
  assign outstanding  = waiting;
  assign results_seen = seen_count;

  // digit d is selectable when the wider limit magnitude (33 bits) needs it
  function automatic bit digit_shown(int d);
    longint a, b, top, lim;
    int i;
    a = longint'(lo_limit);
    b = longint'(hi_limit);
    if (a < 0) a = -a;
    if (b < 0) b = -b;
    top = (a > b) ? a : b;
    if (d == 0) return 1'b1;
    if (d > 9) return 1'b0;
    lim = 9;
    for (i = 1; i < d; i++) lim = lim * 10 + 9;
    return top > lim;
  endfunction

  // screen x of digit d, with group gaps counted away from the dot
  function automatic int glyph_left(int d);
    int x, dot, sp, i;
    x   = int'(unit_edge) - int'(glyph_w);
    dot = int'(dot_pos);
    sp  = int'(gap_w);
    for (i = 1; i <= d; i++) begin
      x -= int'(glyph_w);
      if (i < dot) begin
        if ((dot - i) % 3 == 0) x -= sp;
      end else if (i > dot) begin
        if ((i - dot) % 3 == 0) x -= sp;
      end else begin
        x -= sp;
      end
    end
    return x;
  endfunction

  function automatic logic [DIGIT_W-1:0] touched_digit(int tx);
    int d;
    d = 0;
    while (d < 10) begin
      if (tx > glyph_left(d) || !digit_shown(d + 1)) break;
      d++;
    end
    return DIGIT_W'(d);
  endfunction

  // min is tested first, so on a crossed range values below min settle on min, all others on max
  function automatic longint fit_range(longint v);
    if (v < longint'(lo_limit)) return longint'(lo_limit);
    if (v > longint'(hi_limit)) return longint'(hi_limit);
    return v;
  endfunction

  always @(posedge clk) begin : watch
    editor_view_t want, got;
    longint v, scale;
    logic [DIGIT_W-1:0] d;
    logic flag;
    int i;
    if (rst) begin
      lo_limit  = 32'sh8000_0000;
      hi_limit  = 32'sh7fff_ffff;
      lock_en   = 1'b0;
      dot_pos   = '0;
      glyph_w   = 8'd8;
      gap_w     = 8'd4;
      unit_edge = '0;
      cur_val   = '0;
      shown_val = '0;
      sel_digit = '0;
      view_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_MIN_VALUE: begin
            lo_limit  = cfg.data;
            sel_digit = '0;
          end
          REG_MAX_VALUE: begin
            hi_limit  = cfg.data;
            sel_digit = '0;
          end
          REG_LOCKED:        lock_en   = cfg.data[0];
          REG_DOT_POSITION:  dot_pos   = cfg.data[DOT_W-1:0];
          REG_GLYPH_WIDTH:   glyph_w   = cfg.data[PIX_W-1:0];
          REG_GROUP_SPACING: gap_w     = cfg.data[PIX_W-1:0];
          REG_UNIT_X:        unit_edge = cfg.data[TOUCH_W-1:0];
          default: ;
        endcase
      end

      if (result.valid && result.ready) begin
        seen_count++;
        got.value   = result.value;
        got.digit   = result.selected_digit;
        got.refresh = result.refresh;
        if (view_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: value %0d digit %0d refresh %0b",
                     got.value, got.digit, got.refresh);
        end else begin
          want = view_q.pop_front();
          if (got.value !== want.value || got.digit !== want.digit ||
              got.refresh !== want.refresh) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d wrong: expected value %0d digit %0d refresh %0b,",
                       seen_count, want.value, want.digit, want.refresh,
                       " got value %0d digit %0d refresh %0b",
                       got.value, got.digit, got.refresh);
          end
        end
      end

      if (item.valid && item.ready) begin
        flag = 1'b0;
        if (item.value_write) cur_val = item.new_value;
        v = longint'(cur_val);
        if (!lock_en) begin
          if (item.pressed && !item.disabled) begin
            d = touched_digit(int'(item.touch_x));
            if (d != sel_digit) begin
              sel_digit = d;
              flag      = 1'b1;
            end
          end else if (item.step != 0) begin
            scale = 1;
            for (i = 0; i < int'(sel_digit); i++) scale *= 10;
            v = fit_range(v + scale * longint'(item.step));
          end
        end
        v       = fit_range(v);
        cur_val = v[VALUE_W-1:0];
        if (cur_val != shown_val) begin
          shown_val = cur_val;
          flag      = 1'b1;
        end
        want.value   = cur_val;
        want.digit   = sel_digit;
        want.refresh = flag;
        view_q.push_back(want);
      end
      waiting = view_q.size();
    end
  end

endmodule

// ===== tb/rotary_digit_value_editor_core_test.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the digit editor. Prediction and comparison live in
// the checker instantiated beside the block; this module only drives requests
// and register writes, throttles the result side and decides pass or fail.
module rotary_digit_value_editor_core_test;
  import rdve_pkg::*;

  // no handshake of any kind for this many cycles means the block has hung;
  // the slowest request is a full ten-digit touch walk, the rest is margin for random stalls
  localparam int WATCHDOG_LIMIT = 2000;
  // the 3-bit index has one code with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(REG_UNIT_X) + 1'b1;
  localparam logic signed [VALUE_W-1:0] VALUE_LOWEST  = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_HIGHEST = 32'sh7fff_ffff;
  localparam logic signed [TOUCH_W-1:0] TOUCH_LEFT    = 16'sh8000;
  localparam logic signed [TOUCH_W-1:0] TOUCH_RIGHT   = 16'sh7fff;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rdve_cfg_if    cfg_ch ();
  rdve_item_if   item_ch ();
  rdve_result_if result_ch ();

  int mismatches, pending, results_seen;

  // throttling, in percent per cycle
  int idle_pct  = 0;
  int stall_pct = 0;

  // our copy of the screen geometry, to aim touches near real digit positions
  int cur_ux = 0;
  int cur_gw = 8;
  int cur_sp = 4;

  int requests_sent = 0;
  int reg_writes    = 0;
  int quiet_cycles  = 0;

  rotary_digit_value_editor_core dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (result_ch)
  );

  rotary_digit_value_editor_core_checker editor_check (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg_ch),
    .item         (item_ch),
    .result       (result_ch),
    .mismatches   (mismatches),
    .outstanding  (pending),
    .results_seen (results_seen)
  );

  always #5 clk = ~clk;

  // result side back-pressure, redrawn every cycle
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // hang detection: count cycles with no handshake anywhere
  always @(posedge clk) begin
    if (!rst) begin
      if ((cfg_ch.valid && cfg_ch.ready) || (item_ch.valid && item_ch.ready) ||
          (result_ch.valid && result_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  // All tasks start and end just after a falling edge.

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
    reg_writes++;
    case (index)
      REG_GLYPH_WIDTH:   cur_gw = int'(data[PIX_W-1:0]);
      REG_GROUP_SPACING: cur_sp = int'(data[PIX_W-1:0]);
      REG_UNIT_X:        cur_ux = int'($signed(data[TOUCH_W-1:0]));
      default: ;
    endcase
  endtask

  task automatic send_request(input logic p, input logic dis,
                              input logic signed [TOUCH_W-1:0] tx,
                              input logic signed [STEP_W-1:0] st,
                              input logic vw,
                              input logic signed [VALUE_W-1:0] nv);
    while ($urandom_range(99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.pressed     <= p;
    item_ch.disabled    <= dis;
    item_ch.touch_x     <= tx;
    item_ch.step        <= st;
    item_ch.value_write <= vw;
    item_ch.new_value   <= nv;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
    requests_sent++;
  endtask

  // hold off new requests until every predicted result has come back
  task automatic settle();
    item_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic program_random_setup();
    logic signed [VALUE_W-1:0] lo, hi, a, b;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(4))
      0: begin
        lo = VALUE_LOWEST;
        hi = VALUE_HIGHEST;
      end
      1: begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
      2: begin
        lo = -int'($urandom_range(0, 20000));
        hi = int'($urandom_range(0, 20000));
      end
      3: begin
        // crossed range
        lo = (a < b) ? b : a;
        hi = (a < b) ? a : b;
      end
      default: begin
        lo = $urandom_range(1) ? VALUE_LOWEST : '0;
        hi = (lo == 0) ? VALUE_HIGHEST : '0;
      end
    endcase
    write_reg(REG_MIN_VALUE, lo);
    write_reg(REG_MAX_VALUE, hi);
    write_reg(REG_LOCKED, CFG_DATA_W'($urandom_range(5) == 0));
    write_reg(REG_DOT_POSITION, $urandom_range(15));
    write_reg(REG_GLYPH_WIDTH,
              ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(1, 16));
    write_reg(REG_GROUP_SPACING,
              ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(0, 6));
    write_reg(REG_UNIT_X, $urandom_range(0, 65535));
  endtask

  // mostly touch-then-turn sequences, with disabled touches, locked ticks
  // and out-of-band encoder values mixed in
  task automatic random_request();
    logic p, dis, vw;
    logic signed [TOUCH_W-1:0] tx;
    logic signed [STEP_W-1:0]  st;
    logic signed [VALUE_W-1:0] nv;
    int span;
    p    = ($urandom_range(99) < 40) ? 1'b1 : ($urandom_range(9) == 0);
    dis  = ($urandom_range(7) == 0);
    span = 12 * (cur_gw + cur_sp) + 24;
    tx   = ($urandom_range(3) != 0) ? TOUCH_W'(cur_ux - int'($urandom_range(0, span)))
                                    : TOUCH_W'($urandom);
    st   = ($urandom_range(4) != 0) ? STEP_W'(int'($urandom_range(0, 8)) - 4)
                                    : STEP_W'($urandom);
    vw   = ($urandom_range(9) == 0);
    case ($urandom_range(3))
      0:       nv = $urandom;
      1:       nv = int'($urandom_range(0, 20000)) - 10000;
      2:       nv = VALUE_HIGHEST;
      default: nv = VALUE_LOWEST;
    endcase
    send_request(p, dis, tx, st, vw, nv);
  endtask

  int sender_idle [4]    = '{0, 46, 0, 38};
  int receiver_stall [4] = '{0, 0, 46, 38};

  initial begin
    int ph, blk, n;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    item_ch.valid       = 1'b0;
    item_ch.pressed     = 1'b0;
    item_ch.disabled    = 1'b0;
    item_ch.touch_x     = '0;
    item_ch.step        = '0;
    item_ch.value_write = 1'b0;
    item_ch.new_value   = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed: default geometry, full 32-bit range ---
    // written values at both ends, steps pushing past them
    send_request(1'b0, 1'b0, '0, 8'sd127, 1'b1, VALUE_HIGHEST);
    send_request(1'b0, 1'b0, '0, -8'sd128, 1'b1, VALUE_LOWEST);
    // zero step leaves the value alone
    send_request(1'b0, 1'b0, '0, '0, 1'b0, '0);
    // far-left touch walks to the top digit
    send_request(1'b1, 1'b0, TOUCH_LEFT, '0, 1'b0, '0);
    // steps of 10^9 overflow 32 bits before the clamp
    send_request(1'b0, 1'b0, '0, 8'sd127, 1'b1, '0);
    send_request(1'b0, 1'b0, '0, -8'sd128, 1'b0, '0);
    // touch on digit three, just past the group gap after digit two
    send_request(1'b1, 1'b0, -16'sd30, '0, 1'b0, '0);
    // disabled touch falls through to the encoder step
    send_request(1'b1, 1'b1, TOUCH_RIGHT, -8'sd1, 1'b0, '0);
    send_request(1'b1, 1'b0, TOUCH_RIGHT, 8'sd5, 1'b1, -32'sd1);
    send_request(1'b0, 1'b1, '0, 8'sd1, 1'b1, -32'sd1);

    // locked: touch and encoder ignored, a written value still lands
    settle();
    write_reg(REG_LOCKED, 1);
    send_request(1'b1, 1'b0, TOUCH_LEFT, 8'sd100, 1'b0, '0);
    send_request(1'b0, 1'b0, '0, -8'sd128, 1'b1, 32'sd12345);

    // widest geometry, dot code beyond the nine digits
    settle();
    write_reg(REG_LOCKED, 0);
    write_reg(REG_DOT_POSITION, 15);
    write_reg(REG_GLYPH_WIDTH, 255);
    write_reg(REG_GROUP_SPACING, 255);
    write_reg(REG_UNIT_X, 32'h0000_7fff);
    send_request(1'b1, 1'b0, TOUCH_LEFT, '0, 1'b0, '0);
    send_request(1'b1, 1'b0, 16'sd32167, '0, 1'b0, '0);

    // zero-width glyphs at the left screen edge
    settle();
    write_reg(REG_DOT_POSITION, 9);
    write_reg(REG_GLYPH_WIDTH, 0);
    write_reg(REG_GROUP_SPACING, 0);
    write_reg(REG_UNIT_X, 32'hffff_8000);
    send_request(1'b1, 1'b0, TOUCH_LEFT, '0, 1'b0, '0);
    send_request(1'b1, 1'b0, -16'sd32767, '0, 1'b0, '0);

    // crossed range: min wins below it, max otherwise
    settle();
    write_reg(REG_MIN_VALUE, 100);
    write_reg(REG_MAX_VALUE, -100);
    send_request(1'b0, 1'b0, '0, '0, 1'b1, '0);
    send_request(1'b0, 1'b0, '0, '0, 1'b1, 32'sd500);

    // single-digit range: only digit 0 can be picked
    settle();
    write_reg(REG_MIN_VALUE, -5);
    write_reg(REG_MAX_VALUE, 5);
    send_request(1'b1, 1'b0, TOUCH_LEFT, '0, 1'b0, '0);
    send_request(1'b0, 1'b0, '0, 8'sd127, 1'b0, '0);

    // min of -2^31: its magnitude needs 33 bits to unlock digit 9
    settle();
    write_reg(REG_MIN_VALUE, VALUE_LOWEST);
    write_reg(REG_MAX_VALUE, 0);
    send_request(1'b1, 1'b0, TOUCH_LEFT, '0, 1'b0, '0);
    send_request(1'b0, 1'b0, '0, 8'sd1, 1'b1, VALUE_LOWEST);

    // unused register code must change nothing
    settle();
    write_reg(REG_SPARE, $urandom);
    send_request(1'b0, 1'b0, '0, -8'sd1, 1'b0, '0);

    // --- random: four throttling phases, three setups each ---
    for (ph = 0; ph < 4; ph++) begin
      idle_pct  = sender_idle[ph];
      stall_pct = receiver_stall[ph];
      for (blk = 0; blk < 3; blk++) begin
        settle();
        program_random_setup();
        for (n = 0; n < 50; n++) begin
          // occasional full drain mid-stream
          if ($urandom_range(39) == 0) settle();
          random_request();
        end
      end
    end

    settle();
    repeat (30) @(negedge clk);

    $display("Covered %0d requests, %0d results and %0d register writes,",
             requests_sent, results_seen, reg_writes);
    $display("with limits, crossed ranges, locking and four throttling mixes.");
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rdve_pkg.sv
design/rdve_cfg_if.sv
design/rdve_item_if.sv
design/rdve_result_if.sv
design/rdve_datapath.sv
design/rdve_ctrl.sv
design/rotary_digit_value_editor_core.sv
design/rdve_checker.sv
tb/rotary_digit_value_editor_core_checker.sv
tb/rotary_digit_value_editor_core_test.sv
